// ===== design/tfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_pkg: shared types and constants of the telemetry frame receiver
// Frame layout constants, CRC constants, status codes, register indexes and
// the structures that pass between the receiver's modules.
// ----------------------------------------------------------------------------
package tfr_pkg;

  localparam int MAX_DATAGRAM    = 250;
  localparam int HEADER_BYTES    = 12;
  localparam int TELEMETRY_BYTES = 12;
  localparam int MIN_FRAME_BYTES = HEADER_BYTES + 2;

  localparam logic [7:0]  MAGIC_BYTE = 8'h4C;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_MSB    = 16'h8000;

  localparam logic [7:0]        VERSION_RESET   = 8'd1;
  localparam logic [7:0]        TELEM_RESET     = 8'd1;
  localparam logic [7:0]        HEART_RESET     = 8'd2;
  localparam logic [15:0]       TIMEOUT_RESET   = 16'd5000;
  localparam logic signed [7:0] SIGNAL_RESET    = -8'sd100;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_VERSION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TELEMETRY_TYPE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_TYPE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_TIMEOUT     = 3'd3;

  typedef enum logic [2:0] {
    ST_BUSY   = 3'd0,
    ST_TELEM  = 3'd1,
    ST_HEART  = 3'd2,
    ST_OTHER  = 3'd3,
    ST_SHORT  = 3'd4,
    ST_BADHDR = 3'd5,
    ST_TRUNC  = 3'd6,
    ST_CRC    = 3'd7
  } tfr_status_t;

  typedef logic [TELEMETRY_BYTES-1:0][7:0] tfr_payload_t;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        end_of_datagram;
    logic [31:0] now_ms;
  } tfr_beat_t;

  typedef struct packed {
    logic [7:0]  protocol_version;
    logic [7:0]  telemetry_type;
    logic [7:0]  heartbeat_type;
    logic [15:0] link_timeout_ms;
  } tfr_cfg_t;

  typedef struct packed {
    tfr_status_t  status;
    tfr_payload_t payload;
  } tfr_judge_t;

  typedef struct packed {
    logic [7:0]        motion_code;
    logic [31:0]       step_count;
    logic [15:0]       peak_accel_mg;
    logic [7:0]        confidence;
    logic signed [7:0] signal_dbm;
    logic [7:0]        battery_level;
    logic [31:0]       telemetry_time_ms;
  } tfr_record_t;

  typedef struct packed {
    tfr_status_t frame_status;
    tfr_record_t record;
    logic        link_ok;
  } tfr_result_t;

endpackage

// ===== design/tfr_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_in_if: received byte channel
// Valid/ready channel carrying one datagram byte, its end marker and the time.
// ----------------------------------------------------------------------------
interface tfr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic        end_of_datagram;
  logic [31:0] now_ms;

  modport source (output valid, output rx_byte, output end_of_datagram, output now_ms,
                  input ready);
  modport sink   (input valid, input rx_byte, input end_of_datagram, input now_ms,
                  output ready);
endinterface

// ===== design/tfr_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_out_if: result channel
// Valid/ready channel carrying the frame status, the collar record and link state.
// ----------------------------------------------------------------------------
interface tfr_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        frame_status;
  logic [7:0]        motion_code;
  logic [31:0]       step_count;
  logic [15:0]       peak_accel_mg;
  logic [7:0]        confidence;
  logic signed [7:0] signal_dbm;
  logic [7:0]        battery_level;
  logic [31:0]       telemetry_time_ms;
  logic              link_ok;

  modport source (output valid, output frame_status, output motion_code, output step_count,
                  output peak_accel_mg, output confidence, output signal_dbm,
                  output battery_level, output telemetry_time_ms, output link_ok,
                  input ready);
  modport sink   (input valid, input frame_status, input motion_code, input step_count,
                  input peak_accel_mg, input confidence, input signal_dbm,
                  input battery_level, input telemetry_time_ms, input link_ok,
                  output ready);
endinterface

// ===== design/tfr_frame_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_frame_check: byte-serial frame parser and judge
// Counts datagram bytes, keeps header and payload bytes, runs the CRC-16 and
// captures the trailer; on the end marker it grades the datagram.
// ----------------------------------------------------------------------------
module tfr_frame_check (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  tfr_pkg::tfr_beat_t beat,
  input  tfr_pkg::tfr_cfg_t  cfg,
  output tfr_pkg::tfr_judge_t judge
);

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = ((c & tfr_pkg::CRC_MSB) != 16'h0000) ? ((c << 1) ^ tfr_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  logic [7:0]  count_r, count_nxt, count_take;
  logic [15:0] crc_r, crc_nxt, crc_take;
  logic [15:0] trail_r, trail_nxt, trail_take;
  logic [7:0]  hdr_r [tfr_pkg::HEADER_BYTES];
  logic [7:0]  pay_r [tfr_pkg::TELEMETRY_BYTES];
  logic        take;
  logic        hdr_we, pay_we;
  logic [7:0]  pay_idx;
  logic [8:0]  count9, len9, trail_pos;

  assign take      = count_r < 8'(tfr_pkg::MAX_DATAGRAM);
  assign count9    = {1'b0, count_r};
  assign trail_pos = {1'b0, hdr_r[tfr_pkg::HEADER_BYTES-1]} + 9'(tfr_pkg::HEADER_BYTES);
  assign hdr_we    = take && (count_r < 8'(tfr_pkg::HEADER_BYTES));
  assign pay_idx   = count_r - 8'(tfr_pkg::HEADER_BYTES);
  assign pay_we    = take && !hdr_we && (pay_idx < 8'(tfr_pkg::TELEMETRY_BYTES));

  always_comb begin
    count_take = count_r;
    crc_take   = crc_r;
    trail_take = trail_r;
    if (take) begin
      count_take = count_r + 8'd1;
      if (hdr_we || (count9 < trail_pos)) begin
        crc_take = crc_feed(crc_r, beat.rx_byte);
      end else if (count9 == trail_pos) begin
        trail_take = {trail_r[15:8], beat.rx_byte};
      end else if (count9 == trail_pos + 9'd1) begin
        trail_take = {beat.rx_byte, trail_r[7:0]};
      end
    end
  end

  // Header bytes are only read once all twelve of this datagram are stored (the
  // verdict needs fourteen bytes), so the stored header is always the current one.
  assign len9 = {1'b0, count_take};

  always_comb begin
    judge.status = tfr_pkg::ST_BUSY;
    for (int i = 0; i < tfr_pkg::TELEMETRY_BYTES; i++) begin
      judge.payload[i] = pay_r[i];
    end
    if (beat.end_of_datagram) begin
      if (len9 < 9'(tfr_pkg::MIN_FRAME_BYTES)) begin
        judge.status = tfr_pkg::ST_SHORT;
      end else if (hdr_r[0] != tfr_pkg::MAGIC_BYTE || hdr_r[1] != tfr_pkg::MAGIC_BYTE ||
                   hdr_r[2] != cfg.protocol_version) begin
        judge.status = tfr_pkg::ST_BADHDR;
      end else if (len9 < trail_pos + 9'd2) begin
        judge.status = tfr_pkg::ST_TRUNC;
      end else if (crc_take != trail_take) begin
        judge.status = tfr_pkg::ST_CRC;
      end else if (hdr_r[3] == cfg.telemetry_type &&
                   hdr_r[tfr_pkg::HEADER_BYTES-1] >= 8'(tfr_pkg::TELEMETRY_BYTES)) begin
        judge.status = tfr_pkg::ST_TELEM;
      end else if (hdr_r[3] == cfg.heartbeat_type) begin
        judge.status = tfr_pkg::ST_HEART;
      end else begin
        judge.status = tfr_pkg::ST_OTHER;
      end
    end
  end

  always_comb begin
    if (beat.end_of_datagram) begin
      count_nxt = 8'd0;
      crc_nxt   = tfr_pkg::CRC_INIT;
      trail_nxt = 16'h0000;
    end else begin
      count_nxt = count_take;
      crc_nxt   = crc_take;
      trail_nxt = trail_take;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 8'd0;
      crc_r   <= tfr_pkg::CRC_INIT;
      trail_r <= 16'h0000;
    end else if (step_en) begin
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      trail_r <= trail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && hdr_we) begin
      hdr_r[count_r[3:0]] <= beat.rx_byte;
    end
    if (step_en && pay_we) begin
      pay_r[pay_idx[3:0]] <= beat.rx_byte;
    end
  end

  a_count_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 8'(tfr_pkg::MAX_DATAGRAM))
    else $error("byte count ran past the datagram limit");

  a_restart_on_end : assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && beat.end_of_datagram) |=> (count_r == 8'd0 && crc_r == tfr_pkg::CRC_INIT))
    else $error("frame state not restarted after an end-marked beat");

endmodule

// ===== design/tfr_record.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_record: collar record store and link freshness
// Loads the record from an accepted telemetry frame, tracks the last good
// frame time and works out whether the link is still fresh.
// ----------------------------------------------------------------------------
module tfr_record (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  tfr_pkg::tfr_judge_t judge,
  input  logic [31:0]         now_ms,
  input  logic [15:0]         link_timeout_ms,
  output tfr_pkg::tfr_record_t record_nxt,
  output logic                link_ok
);

  tfr_pkg::tfr_record_t record_r;
  logic [31:0] last_good_r, last_good_nxt;
  logic        seen_r, seen_nxt;
  logic        telem, good;
  logic [31:0] age;

  assign telem = judge.status == tfr_pkg::ST_TELEM;
  assign good  = telem || (judge.status == tfr_pkg::ST_HEART);

  always_comb begin
    record_nxt = record_r;
    if (telem) begin
      record_nxt.motion_code       = judge.payload[0];
      record_nxt.step_count        = {judge.payload[4], judge.payload[3],
                                      judge.payload[2], judge.payload[1]};
      record_nxt.peak_accel_mg     = {judge.payload[6], judge.payload[5]};
      record_nxt.confidence        = judge.payload[7];
      record_nxt.signal_dbm        = $signed(judge.payload[8]);
      record_nxt.battery_level     = judge.payload[9];
      record_nxt.telemetry_time_ms = now_ms;
    end
  end

  assign last_good_nxt = good ? now_ms : last_good_r;
  assign seen_nxt      = good || seen_r;
  // The subtraction wraps with the millisecond counter.
  assign age           = now_ms - last_good_nxt;
  assign link_ok       = seen_nxt && (age < {16'h0000, link_timeout_ms});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_r.motion_code       <= 8'd0;
      record_r.step_count        <= 32'd0;
      record_r.peak_accel_mg     <= 16'd0;
      record_r.confidence        <= 8'd0;
      record_r.signal_dbm        <= tfr_pkg::SIGNAL_RESET;
      record_r.battery_level     <= 8'd0;
      record_r.telemetry_time_ms <= 32'd0;
      last_good_r                <= 32'd0;
      seen_r                     <= 1'b0;
    end else if (step_en) begin
      record_r    <= record_nxt;
      last_good_r <= last_good_nxt;
      seen_r      <= seen_nxt;
    end
  end

  a_telem_time : assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && telem) |=> (record_r.telemetry_time_ms == $past(now_ms) &&
                            last_good_r == $past(now_ms)))
    else $error("accepted telemetry did not stamp the record time");

  a_seen_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(seen_r))
    else $error("link seen flag dropped without reset");

endmodule

// ===== design/telemetry_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_frame_receiver: framed telemetry datagram receiver
// Checks CRC-16 framed datagrams byte by byte and keeps the collar record.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one datagram byte per beat, with end_of_datagram on the
//   final byte and the current millisecond time. Every accepted beat yields
//   exactly one result beat on out_if: status 0 while a datagram is still
//   coming in, and the verdict on the end-marked byte, always together with
//   the stored collar record and the link freshness flag after that byte.
//   The cfg_we / cfg_index / cfg_data port writes the four registers; write
//   them only while no beat is in flight.
//   A beat accepted on in_if is parsed in the input register and moves into
//   the output register that drives out_if once that register is free.
//   Throughput is one beat per cycle while out_if takes its results, set
//   by the combinational CRC byte update and judge between the two registers.
//   A stalled out_if holds the result; the input register still takes one
//   more beat, after which in_if.ready drops until the result is taken.
//   Synchronous reset clears the frame parser, the record (signal -100 dBm)
//   and the link state, empties both pipeline registers and loads register defaults.
// ----------------------------------------------------------------------------
module telemetry_frame_receiver (
  input  logic                            clk,
  input  logic                            rst_n,
  tfr_in_if.sink                          in_if,
  tfr_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  logic [tfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                     cfg_data
);

  tfr_pkg::tfr_cfg_t    cfg_r;
  tfr_pkg::tfr_beat_t   s1_beat_r;
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  tfr_pkg::tfr_result_t out_res_r;
  logic                 advance, in_take;
  tfr_pkg::tfr_judge_t  judge;
  tfr_pkg::tfr_record_t record_nxt;
  logic                 link_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.protocol_version <= tfr_pkg::VERSION_RESET;
      cfg_r.telemetry_type   <= tfr_pkg::TELEM_RESET;
      cfg_r.heartbeat_type   <= tfr_pkg::HEART_RESET;
      cfg_r.link_timeout_ms  <= tfr_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tfr_pkg::CFG_PROTOCOL_VERSION: cfg_r.protocol_version <= cfg_data[7:0];
        tfr_pkg::CFG_TELEMETRY_TYPE:   cfg_r.telemetry_type   <= cfg_data[7:0];
        tfr_pkg::CFG_HEARTBEAT_TYPE:   cfg_r.heartbeat_type   <= cfg_data[7:0];
        tfr_pkg::CFG_LINK_TIMEOUT:     cfg_r.link_timeout_ms  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The input register moves on whenever the output register is empty or
  // its beat is being taken this cycle.
  assign advance     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || advance;
  assign in_take     = in_if.valid && in_if.ready;

  assign s1_valid_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_beat_r.rx_byte         <= in_if.rx_byte;
      s1_beat_r.end_of_datagram <= in_if.end_of_datagram;
      s1_beat_r.now_ms          <= in_if.now_ms;
    end
    if (advance) begin
      out_res_r.frame_status <= judge.status;
      out_res_r.record       <= record_nxt;
      out_res_r.link_ok      <= link_ok;
    end
  end

  tfr_frame_check u_frame_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .beat    (s1_beat_r),
    .cfg     (cfg_r),
    .judge   (judge)
  );

  tfr_record u_record (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (advance),
    .judge           (judge),
    .now_ms          (s1_beat_r.now_ms),
    .link_timeout_ms (cfg_r.link_timeout_ms),
    .record_nxt      (record_nxt),
    .link_ok         (link_ok)
  );

  assign out_if.valid             = out_valid_r;
  assign out_if.frame_status      = out_res_r.frame_status;
  assign out_if.motion_code       = out_res_r.record.motion_code;
  assign out_if.step_count        = out_res_r.record.step_count;
  assign out_if.peak_accel_mg     = out_res_r.record.peak_accel_mg;
  assign out_if.confidence        = out_res_r.record.confidence;
  assign out_if.signal_dbm        = out_res_r.record.signal_dbm;
  assign out_if.battery_level     = out_res_r.record.battery_level;
  assign out_if.telemetry_time_ms = out_res_r.record.telemetry_time_ms;
  assign out_if.link_ok           = out_res_r.link_ok;

  a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (s1_valid_r && out_valid_r && !out_if.ready))
    else $error("input stalled while the pipeline had room");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the telemetry frame receiver
// Builds framed datagrams (good telemetry and heartbeat frames, foreign types,
// broken headers, bad CRCs, truncated, short, oversized and padded datagrams
// and plain noise), streams them one byte per beat with random gaps and output
// stalls, and checks every result beat against an in-bench model of the frame
// parser, the collar record and the link timer, over several register settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO   = 1;
  localparam int FILL_ONES   = 2;

  logic clk;
  logic rst_n;
  logic                          cfg_we;
  logic [tfr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0]                   cfg_data;

  tfr_in_if  in_ch ();
  tfr_out_if out_ch ();

  telemetry_frame_receiver u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Byte beats waiting for the driver and result beats waiting for the DUT
  tfr_pkg::tfr_beat_t   byte_q[$];
  tfr_pkg::tfr_result_t verdict_q[$];
  logic [7:0]           frame_buf[$];

  // Model of the receiver: register copy, parser state and collar record
  tfr_pkg::tfr_cfg_t    mdl_cfg;
  int                   rx_count;
  logic [15:0]          run_crc;
  logic [15:0]          trl_crc;
  logic [7:0]           hdr [tfr_pkg::HEADER_BYTES];
  logic [7:0]           stage [tfr_pkg::TELEMETRY_BYTES];
  tfr_pkg::tfr_record_t rec;
  logic [31:0]          last_good;
  logic                 link_seen;

  logic [31:0] clock_ms;
  int          beats_queued;
  int          checked_beats;
  int          datagrams_sent;
  int          settings_used;
  int          err_count;
  int          verdict_tally [8];

  logic                 in_fire, out_fire;
  int                   in_gap, out_stall;
  logic                 in_calm, out_calm;
  tfr_pkg::tfr_beat_t   nxt_beat, seen_beat;
  tfr_pkg::tfr_result_t want;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    c = crc ^ {d, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = ((c & tfr_pkg::CRC_MSB) != 16'h0000) ? ((c << 1) ^ tfr_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  task automatic track_byte(input tfr_pkg::tfr_beat_t b, output tfr_pkg::tfr_result_t r);
    tfr_pkg::tfr_status_t st;
    int                   plen;
    logic [31:0]          age;
    st = tfr_pkg::ST_BUSY;
    if (rx_count < tfr_pkg::MAX_DATAGRAM) begin
      if (rx_count < tfr_pkg::HEADER_BYTES) begin
        hdr[rx_count] = b.rx_byte;
        run_crc = crc_step(run_crc, b.rx_byte);
      end else begin
        plen = int'(hdr[tfr_pkg::HEADER_BYTES-1]);
        if (rx_count - tfr_pkg::HEADER_BYTES < tfr_pkg::TELEMETRY_BYTES)
          stage[rx_count-tfr_pkg::HEADER_BYTES] = b.rx_byte;
        if (rx_count < tfr_pkg::HEADER_BYTES + plen) run_crc = crc_step(run_crc, b.rx_byte);
        else if (rx_count == tfr_pkg::HEADER_BYTES + plen) trl_crc[7:0] = b.rx_byte;
        else if (rx_count == tfr_pkg::HEADER_BYTES + plen + 1) trl_crc[15:8] = b.rx_byte;
      end
      rx_count++;
    end
    if (b.end_of_datagram) begin
      plen = int'(hdr[tfr_pkg::HEADER_BYTES-1]);
      if (rx_count < tfr_pkg::MIN_FRAME_BYTES) begin
        st = tfr_pkg::ST_SHORT;
      end else if (hdr[0] != tfr_pkg::MAGIC_BYTE || hdr[1] != tfr_pkg::MAGIC_BYTE ||
                   hdr[2] != mdl_cfg.protocol_version) begin
        st = tfr_pkg::ST_BADHDR;
      end else if (rx_count < tfr_pkg::HEADER_BYTES + plen + 2) begin
        st = tfr_pkg::ST_TRUNC;
      end else if (run_crc != trl_crc) begin
        st = tfr_pkg::ST_CRC;
      end else if (hdr[3] == mdl_cfg.telemetry_type && plen >= tfr_pkg::TELEMETRY_BYTES) begin
        rec.motion_code       = stage[0];
        rec.step_count        = {stage[4], stage[3], stage[2], stage[1]};
        rec.peak_accel_mg     = {stage[6], stage[5]};
        rec.confidence        = stage[7];
        rec.signal_dbm        = stage[8];
        rec.battery_level     = stage[9];
        rec.telemetry_time_ms = b.now_ms;
        last_good = b.now_ms;
        link_seen = 1'b1;
        st = tfr_pkg::ST_TELEM;
      end else if (hdr[3] == mdl_cfg.heartbeat_type) begin
        last_good = b.now_ms;
        link_seen = 1'b1;
        st = tfr_pkg::ST_HEART;
      end else begin
        st = tfr_pkg::ST_OTHER;
      end
      verdict_tally[st]++;
      rx_count = 0;
      run_crc  = tfr_pkg::CRC_INIT;
      trl_crc  = 16'h0000;
    end
    age = b.now_ms - last_good;
    r.frame_status = st;
    r.record       = rec;
    r.link_ok      = link_seen && (age < {16'h0000, mdl_cfg.link_timeout_ms});
  endtask

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic note_field(input string field, input logic [31:0] exp_v,
                            input logic [31:0] act_v);
    note_error($sformatf("mismatch on %s: expected 0x%0h, got 0x%0h", field, exp_v, act_v));
  endtask

  // Sampling at the rising edge: acceptance flags, result check, prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= in_ch.valid && in_ch.ready;
      out_fire <= out_ch.valid && out_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          note_error("result beat with nothing expected");
        end else begin
          want = verdict_q.pop_front();
          if (out_ch.frame_status !== want.frame_status)
            note_field("frame_status", 32'(want.frame_status), 32'(out_ch.frame_status));
          if (out_ch.motion_code !== want.record.motion_code)
            note_field("motion_code", 32'(want.record.motion_code),
                       32'(out_ch.motion_code));
          if (out_ch.step_count !== want.record.step_count)
            note_field("step_count", want.record.step_count, out_ch.step_count);
          if (out_ch.peak_accel_mg !== want.record.peak_accel_mg)
            note_field("peak_accel_mg", 32'(want.record.peak_accel_mg),
                       32'(out_ch.peak_accel_mg));
          if (out_ch.confidence !== want.record.confidence)
            note_field("confidence", 32'(want.record.confidence), 32'(out_ch.confidence));
          if (out_ch.signal_dbm !== want.record.signal_dbm)
            note_field("signal_dbm", 32'(want.record.signal_dbm), 32'(out_ch.signal_dbm));
          if (out_ch.battery_level !== want.record.battery_level)
            note_field("battery_level", 32'(want.record.battery_level),
                       32'(out_ch.battery_level));
          if (out_ch.telemetry_time_ms !== want.record.telemetry_time_ms)
            note_field("telemetry_time_ms", want.record.telemetry_time_ms,
                       out_ch.telemetry_time_ms);
          if (out_ch.link_ok !== want.link_ok)
            note_field("link_ok", 32'(want.link_ok), 32'(out_ch.link_ok));
          checked_beats++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen_beat.rx_byte         = in_ch.rx_byte;
        seen_beat.end_of_datagram = in_ch.end_of_datagram;
        seen_beat.now_ms          = in_ch.now_ms;
        track_byte(seen_beat, want);
        verdict_q.push_back(want);
      end
    end
  end

  // Byte driver: holds a beat until it is taken, then waits its drawn gap
  always @(negedge clk) begin
    if (rst_n) begin
      if (!(in_ch.valid && !in_fire)) begin
        if (in_ch.valid) begin
          if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
          in_gap = in_calm ? 0 : $urandom_range(0, 16);
        end
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          nxt_beat = byte_q.pop_front();
          in_ch.rx_byte         <= nxt_beat.rx_byte;
          in_ch.end_of_datagram <= nxt_beat.end_of_datagram;
          in_ch.now_ms          <= nxt_beat.now_ms;
          in_ch.valid           <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result sink: a fresh stall is drawn for every result beat taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire) begin
        if ($urandom_range(0, 49) == 0) out_calm = !out_calm;
        out_stall = out_calm ? 0 : $urandom_range(0, 16);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [tfr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    case (idx)
      tfr_pkg::CFG_PROTOCOL_VERSION: mdl_cfg.protocol_version = data[7:0];
      tfr_pkg::CFG_TELEMETRY_TYPE:   mdl_cfg.telemetry_type   = data[7:0];
      tfr_pkg::CFG_HEARTBEAT_TYPE:   mdl_cfg.heartbeat_type   = data[7:0];
      tfr_pkg::CFG_LINK_TIMEOUT:     mdl_cfg.link_timeout_ms  = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(input logic [7:0] ver, input logic [7:0] tel,
                            input logic [7:0] hb, input logic [15:0] tmo);
    write_reg(tfr_pkg::CFG_PROTOCOL_VERSION, {8'h00, ver});
    write_reg(tfr_pkg::CFG_TELEMETRY_TYPE, {8'h00, tel});
    write_reg(tfr_pkg::CFG_HEARTBEAT_TYPE, {8'h00, hb});
    write_reg(tfr_pkg::CFG_LINK_TIMEOUT, tmo);
    settings_used++;
  endtask

  // Header: magic, version, type, random flags, sequence and sender time, length
  task automatic make_good(input logic [7:0] typ, input int plen, input int fill,
                           input bit corrupt);
    logic [15:0] c;
    frame_buf.delete();
    frame_buf.push_back(tfr_pkg::MAGIC_BYTE);
    frame_buf.push_back(tfr_pkg::MAGIC_BYTE);
    frame_buf.push_back(mdl_cfg.protocol_version);
    frame_buf.push_back(typ);
    repeat (7) frame_buf.push_back(8'($urandom_range(0, 255)));
    frame_buf.push_back(plen[7:0]);
    repeat (plen) begin
      case (fill)
        FILL_ZERO: frame_buf.push_back(8'h00);
        FILL_ONES: frame_buf.push_back(8'hFF);
        default:   frame_buf.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    c = tfr_pkg::CRC_INIT;
    foreach (frame_buf[i]) c = crc_step(c, frame_buf[i]);
    if (corrupt) c = c ^ (16'h0001 << $urandom_range(0, 15));
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
  endtask

  // Times mostly creep forward; some gaps straddle the link timeout, a few jump anywhere
  task automatic send_datagram();
    tfr_pkg::tfr_beat_t b;
    int                 r;
    r = $urandom_range(0, 15);
    if (r == 0) clock_ms = $urandom;
    else if (r <= 4) clock_ms = clock_ms + mdl_cfg.link_timeout_ms + $urandom_range(0, 40) - 20;
    else clock_ms = clock_ms + $urandom_range(0, 60);
    foreach (frame_buf[i]) begin
      b.rx_byte         = frame_buf[i];
      b.end_of_datagram = (i == frame_buf.size() - 1);
      b.now_ms          = ($urandom_range(0, 31) == 0) ? $urandom : clock_ms;
      clock_ms          = clock_ms + $urandom_range(0, 2);
      byte_q.push_back(b);
      beats_queued++;
    end
    datagrams_sent++;
  endtask

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 2))
      0:       return mdl_cfg.telemetry_type;
      1:       return mdl_cfg.heartbeat_type;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic emit_random();
    int         r, plen;
    logic [7:0] typ;
    r    = $urandom_range(0, 99);
    plen = $urandom_range(0, 16);
    if (r < 30) begin
      make_good(mdl_cfg.telemetry_type, $urandom_range(12, 20), FILL_RANDOM, 0);
    end else if (r < 45) begin
      make_good(mdl_cfg.heartbeat_type, $urandom_range(0, 4), FILL_RANDOM, 0);
    end else if (r < 52) begin
      do typ = 8'($urandom_range(0, 255));
      while (typ == mdl_cfg.telemetry_type || typ == mdl_cfg.heartbeat_type);
      make_good(typ, plen, FILL_RANDOM, 0);
    end else if (r < 58) begin
      make_good(mdl_cfg.telemetry_type, $urandom_range(0, 11), FILL_RANDOM, 0);
    end else if (r < 66) begin
      make_good(pick_type(), plen, FILL_RANDOM, 1);
    end else if (r < 71) begin
      make_good(pick_type(), plen, FILL_RANDOM, 0);
      r = $urandom_range(0, 1);
      frame_buf[r] = frame_buf[r] ^ 8'($urandom_range(1, 255));
    end else if (r < 76) begin
      make_good(pick_type(), plen, FILL_RANDOM, 0);
      frame_buf[2] = frame_buf[2] ^ 8'($urandom_range(1, 255));
    end else if (r < 83) begin
      make_good(pick_type(), plen, FILL_RANDOM, 0);
      repeat ($urandom_range(1, plen + 2)) void'(frame_buf.pop_back());
    end else if (r < 88) begin
      make_good(mdl_cfg.heartbeat_type, 0, FILL_RANDOM, 0);
      repeat ($urandom_range(1, 13)) void'(frame_buf.pop_back());
    end else if (r < 94) begin
      make_good(pick_type(), plen, FILL_RANDOM, 0);
      repeat ($urandom_range(1, 6)) frame_buf.push_back(8'($urandom_range(0, 255)));
    end else if (r < 99) begin
      frame_buf.delete();
      repeat ($urandom_range(1, 30)) frame_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      make_good(mdl_cfg.telemetry_type, $urandom_range(237, 255), FILL_RANDOM, 0);
    end
    send_datagram();
  endtask

  task automatic fill_random(input int beats);
    int start, frames;
    start  = beats_queued;
    frames = 0;
    while (beats_queued - start < beats || frames < 2) begin
      emit_random();
      frames++;
    end
  endtask

  // Waits until every byte queued so far has produced its checked result
  task automatic wait_drained();
    do @(negedge clk);
    while (checked_beats != beats_queued);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    #20_000_000;
    $display("FAIL telemetry_frame_receiver");
    $finish;
  end

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = tfr_pkg::CFG_PROTOCOL_VERSION;
    cfg_data              = 16'h0000;
    in_ch.valid           = 1'b0;
    in_ch.rx_byte         = 8'h00;
    in_ch.end_of_datagram = 1'b0;
    in_ch.now_ms          = 32'h0;
    out_ch.ready          = 1'b0;
    in_gap = 0;   out_stall = 0;
    in_calm = 1'b0; out_calm = 1'b0;
    beats_queued = 0; checked_beats = 0; datagrams_sent = 0;
    settings_used = 1; err_count = 0;
    foreach (verdict_tally[i]) verdict_tally[i] = 0;
    mdl_cfg = '{tfr_pkg::VERSION_RESET, tfr_pkg::TELEM_RESET, tfr_pkg::HEART_RESET,
                tfr_pkg::TIMEOUT_RESET};
    rx_count  = 0;
    run_crc   = tfr_pkg::CRC_INIT;
    trl_crc   = 16'h0000;
    rec       = '0;
    rec.signal_dbm = tfr_pkg::SIGNAL_RESET;
    last_good = 32'h0;
    link_seen = 1'b0;
    clock_ms  = 32'd1000;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed datagrams under the reset register values
    make_good(mdl_cfg.telemetry_type, 12, FILL_ZERO, 0); send_datagram();
    make_good(mdl_cfg.telemetry_type, 12, FILL_ONES, 0); send_datagram();
    make_good(mdl_cfg.telemetry_type, 40, FILL_RANDOM, 0); send_datagram();
    // A telemetry type with too little payload is not taken as telemetry
    make_good(mdl_cfg.telemetry_type, 11, FILL_RANDOM, 0); send_datagram();
    make_good(mdl_cfg.heartbeat_type, 0, FILL_RANDOM, 0); send_datagram();
    make_good(8'hFF, 3, FILL_RANDOM, 0); send_datagram();
    make_good(mdl_cfg.heartbeat_type, 5, FILL_RANDOM, 1); send_datagram();
    make_good(mdl_cfg.telemetry_type, 12, FILL_RANDOM, 0);
    frame_buf[0] = 8'h4D; send_datagram();
    make_good(mdl_cfg.telemetry_type, 12, FILL_RANDOM, 0);
    frame_buf[1] = 8'h00; send_datagram();
    make_good(mdl_cfg.telemetry_type, 12, FILL_RANDOM, 0);
    frame_buf[2] = 8'hFE; send_datagram();
    make_good(mdl_cfg.telemetry_type, 20, FILL_RANDOM, 0);
    repeat (3) void'(frame_buf.pop_back());
    send_datagram();
    frame_buf.delete();
    frame_buf.push_back(tfr_pkg::MAGIC_BYTE); send_datagram();
    make_good(mdl_cfg.heartbeat_type, 0, FILL_RANDOM, 0);
    void'(frame_buf.pop_back());
    send_datagram();
    make_good(mdl_cfg.telemetry_type, 12, FILL_RANDOM, 0);
    repeat (5) frame_buf.push_back(8'($urandom_range(0, 255)));
    send_datagram();
    // Declared length beyond the datagram limit can only end up truncated
    make_good(mdl_cfg.telemetry_type, 255, FILL_RANDOM, 0); send_datagram();
    // Frame fills the limit exactly; the padding after it is dropped
    make_good(mdl_cfg.telemetry_type, 236, FILL_RANDOM, 0);
    repeat (20) frame_buf.push_back(8'($urandom_range(0, 255)));
    send_datagram();
    frame_buf.delete();
    repeat (20) frame_buf.push_back(8'($urandom_range(0, 255)));
    send_datagram();
    make_good(mdl_cfg.heartbeat_type, 2, FILL_RANDOM, 0); send_datagram();
    wait_drained();

    set_config(8'd0, 8'd255, 8'd0, 16'd1);
    fill_random(30);
    wait_drained();
    set_config(8'd255, 8'd0, 8'd255, 16'd65535);
    clock_ms = 32'hFFFF_F000;
    fill_random(30);
    wait_drained();
    // Equal type codes: telemetry wins when the payload is long enough
    set_config(8'd7, 8'd9, 8'd9, 16'd300);
    fill_random(30);
    wait_drained();
    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 16'($urandom_range(1, 65535)));
    fill_random(30);
    wait_drained();
    set_config(tfr_pkg::VERSION_RESET, tfr_pkg::TELEM_RESET, tfr_pkg::HEART_RESET,
               tfr_pkg::TIMEOUT_RESET);
    fill_random(30);
    wait_drained();

    $display("Run covered %0d datagrams in %0d byte beats under %0d register settings.",
             datagrams_sent, checked_beats, settings_used);
    $display("Verdicts: telemetry %0d, heartbeat %0d, ignored %0d, short %0d,",
             verdict_tally[tfr_pkg::ST_TELEM], verdict_tally[tfr_pkg::ST_HEART],
             verdict_tally[tfr_pkg::ST_OTHER], verdict_tally[tfr_pkg::ST_SHORT]);
    $display("          bad header %0d, truncated %0d, crc %0d.",
             verdict_tally[tfr_pkg::ST_BADHDR], verdict_tally[tfr_pkg::ST_TRUNC],
             verdict_tally[tfr_pkg::ST_CRC]);
    if (err_count == 0) begin
      $display("PASS telemetry_frame_receiver");
    end else begin
      $display("FAIL telemetry_frame_receiver");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tfr_pkg.sv
design/tfr_in_if.sv
design/tfr_out_if.sv
design/tfr_frame_check.sv
design/tfr_record.sv
design/telemetry_frame_receiver.sv
dv/tb_top.sv
